// ===== hw/rtl/pcds_pkg.sv =====
package pcds_pkg;

    localparam int MAX_BINS  = 1024;
    localparam int BIN_W     = 10;
    localparam int CNT_W     = 11;
    localparam int WGT_W     = 16;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 17;
    localparam int TOT_W     = 26;
    localparam int DENS_W    = 27;
    localparam int UN_W      = 27;
    localparam int DIV_W     = 42;
    localparam int DCNT_W    = 6;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 120;
    localparam int PAD_W     = OUT_W - (BIN_W + 3 * Q_W + DENS_W + TOT_W);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_FIN    = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        DV_FRAC,
        DV_POS,
        DV_LIM,
        DV_DENS,
        DV_PROB
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_LOAD,
        S_NR,
        S_FIN_RD,
        S_FIN_ACC,
        S_FIN_END,
        S_MUL,
        S_BRANCH,
        S_QOFF,
        S_ZEDGE,
        S_U0,
        S_SRCH_ISSUE,
        S_SRCH_CMP,
        S_SRCH_END,
        S_WRD,
        S_WTAKE,
        S_WMUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     cap_in;
        logic     dispatch;
        logic     load_do;
        logic     not_ready;
        logic     fin_rd;
        logic     fin_acc;
        logic     fin_end;
        logic     mul;
        logic     zedge;
        logic     qoff;
        logic     u0;
        logic     srch_issue;
        logic     srch_cmp;
        logic     srch_end;
        logic     wrd;
        logic     wtake;
        logic     wmul;
        logic     div_start;
        logic     div_take;
        div_sel_t div_sel;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic table_ready;
        logic total_zero;
        logic u_zero;
        logic fin_last;
        logic srch_more;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/pcds_div.sv =====
module pcds_div
    import pcds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [TOT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [TOT_W:0]    shifted;
    logic              fits;

    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DCNT_W'(DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? TOT_W'(shifted - {1'b0, dsr_reg}) : shifted[TOT_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hw/rtl/pcds_ctrl.sv =====
module pcds_ctrl
    import pcds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DV_FRAC;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.dispatch = 1'b1;
                case (stat.cmd)
                    CMD_LOAD: state_next = S_LOAD;
                    CMD_FIN:  state_next = S_FIN_RD;
                    default:  state_next = stat.table_ready ? S_MUL : S_NR;
                endcase
            end
            S_LOAD:
            begin
                cmd.load_do = 1'b1;
                state_next  = S_OUT;
            end
            S_NR:
            begin
                cmd.not_ready = 1'b1;
                state_next    = S_OUT;
            end
            S_FIN_RD:
            begin
                cmd.fin_rd = 1'b1;
                state_next = S_FIN_ACC;
            end
            S_FIN_ACC:
            begin
                cmd.fin_acc = 1'b1;
                state_next  = stat.fin_last ? S_FIN_END : S_FIN_RD;
            end
            S_FIN_END:
            begin
                cmd.fin_end = 1'b1;
                state_next  = S_OUT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (stat.cmd == CMD_QUERY)
                    state_next = S_QOFF;
                else if (stat.total_zero)
                    state_next = S_ZEDGE;
                else if (stat.u_zero)
                    state_next = S_U0;
                else
                    state_next = S_SRCH_ISSUE;
            end
            S_QOFF:
            begin
                cmd.qoff   = 1'b1;
                state_next = stat.total_zero ? S_OUT : S_WRD;
            end
            S_ZEDGE:
            begin
                cmd.zedge  = 1'b1;
                state_next = S_OUT;
            end
            S_U0:
            begin
                cmd.u0     = 1'b1;
                state_next = S_WRD;
            end
            S_SRCH_ISSUE:
            begin
                if (stat.srch_more)
                begin
                    cmd.srch_issue = 1'b1;
                    state_next     = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_SRCH_END;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH_ISSUE;
            end
            S_SRCH_END:
            begin
                cmd.srch_end = 1'b1;
                state_next   = S_WRD;
            end
            S_WRD:
            begin
                cmd.wrd    = 1'b1;
                state_next = S_WTAKE;
            end
            S_WTAKE:
            begin
                cmd.wtake  = 1'b1;
                state_next = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.wmul   = 1'b1;
                sel_next   = (stat.cmd == CMD_SAMPLE && !stat.u_zero) ? DV_FRAC : DV_DENS;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_DIV_GO;
                    case (sel_reg)
                        DV_FRAC: sel_next = DV_POS;
                        DV_POS:  sel_next = DV_LIM;
                        DV_LIM:  sel_next = DV_DENS;
                        DV_DENS: sel_next = DV_PROB;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/pcds_dpath.sv =====
module pcds_dpath
    import pcds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic [1:0]        m_tuser,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat
);

    logic [WGT_W-1:0] wmem [MAX_BINS];
    logic [TOT_W-1:0] pmem [MAX_BINS+1];

    cmd_t             cmd_reg;
    logic [WGT_W-1:0] w_in_reg, u_reg, w_reg;
    logic [CNT_W-1:0] ac_reg, lp_reg, nr_reg, i_reg, lo_reg, hi_reg, mid_reg;
    logic [TOT_W-1:0] tot_reg, acc_reg, p_reg, wn_reg;
    logic             tr_reg;
    logic [BIN_W-1:0] off_reg;
    logic [DIV_W-1:0] t_reg;
    logic [UN_W-1:0]  un_reg;

    logic [BIN_W-1:0]  res_bin_reg;
    logic [Q_W-1:0]    res_frac_reg, res_pos_reg, res_prob_reg;
    logic [DENS_W-1:0] res_dens_reg;
    logic [TOT_W-1:0]  res_tot_reg;
    status_t           res_st_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    logic [CNT_W-1:0] n_eff, lp_eff, nr_m1, off_lo, off_q;
    logic [CNT_W:0]   mid_sum;
    logic [WGT_W-1:0] w_rdata, w_eff;
    logic [TOT_W-1:0] p_rdata, acc_next;
    logic             w_we;
    logic [BIN_W-1:0] w_waddr, w_raddr;
    logic [WGT_W-1:0] w_wdata;
    logic [CNT_W-1:0] p_raddr;
    logic [DIV_W-1:0] div_dvd;
    logic [TOT_W-1:0] div_dsr;
    logic [DIV_W-1:0] div_q;
    logic             div_done;
    logic [Q_W-1:0]   lim;

    always_comb
    begin
        if (ac_reg == '0)
            n_eff = CNT_W'(1);
        else if (ac_reg > CNT_W'(MAX_BINS))
            n_eff = CNT_W'(MAX_BINS);
        else
            n_eff = ac_reg;
    end

    assign lp_eff   = tr_reg ? '0 : lp_reg;
    assign nr_m1    = nr_reg - 1'b1;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + (CNT_W+1)'(1);
    assign off_lo   = (lo_reg > nr_m1) ? nr_m1 : lo_reg;
    assign off_q    = (un_reg[UN_W-1:FRAC_BITS] > nr_m1) ? nr_m1 : un_reg[UN_W-1:FRAC_BITS];
    assign w_eff    = (i_reg < lp_reg) ? w_rdata : '0;
    assign acc_next = acc_reg + TOT_W'(w_eff);
    assign lim      = div_q[Q_W-1:0] - 1'b1;

    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = i_reg[BIN_W-1:0];
        w_wdata = '0;
        if (cmd.load_do && lp_eff < n_eff)
        begin
            w_we    = 1'b1;
            w_waddr = lp_eff[BIN_W-1:0];
            w_wdata = w_in_reg;
        end
        else if (cmd.fin_acc && i_reg >= lp_reg)
        begin
            w_we = 1'b1;
        end
    end

    assign w_raddr = cmd.fin_rd ? i_reg[BIN_W-1:0] : off_reg;
    assign p_raddr = cmd.srch_issue ? mid_sum[CNT_W:1] : {1'b0, off_reg};

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= w_wdata;
        if (cmd.fin_rd || cmd.wrd)
            w_rdata <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_acc)
            pmem[i_reg + 1'b1] <= acc_next;
        if (cmd.srch_issue || cmd.wrd)
            p_rdata <= pmem[p_raddr];
    end

    always_comb
    begin
        div_dvd = '0;
        div_dsr = tot_reg;
        case (cmd.div_sel)
            DV_FRAC:
            begin
                div_dvd = t_reg - {p_reg, FRAC_BITS'(0)};
                div_dsr = TOT_W'(w_reg);
            end
            DV_POS:
            begin
                div_dvd = DIV_W'({off_reg, FRAC_BITS'(0)}) + DIV_W'(res_frac_reg);
                div_dsr = TOT_W'(nr_reg);
            end
            DV_LIM:
            begin
                div_dvd = DIV_W'({off_reg, FRAC_BITS'(0)}) + (DIV_W'(1) << FRAC_BITS)
                        + DIV_W'(nr_reg) - DIV_W'(1);
                div_dsr = TOT_W'(nr_reg);
            end
            DV_DENS: div_dvd = {wn_reg, FRAC_BITS'(0)};
            DV_PROB: div_dvd = DIV_W'({w_reg, FRAC_BITS'(0)});
            default: div_dvd = '0;
        endcase
    end

    pcds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_reg       <= CNT_W'(MAX_BINS);
            lp_reg       <= '0;
            tot_reg      <= '0;
            tr_reg       <= 1'b0;
            nr_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ac_reg <= cfg_data;
            if (cmd.load_do)
            begin
                tr_reg <= 1'b0;
                if (tr_reg)
                    tot_reg <= '0;
                lp_reg <= (lp_eff < n_eff) ? lp_eff + 1'b1 : lp_eff;
            end
            if (cmd.fin_end)
            begin
                tot_reg <= acc_reg;
                nr_reg  <= n_eff;
                tr_reg  <= 1'b1;
            end
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            w_in_reg <= s_tdata[WGT_W-1:0];
            u_reg    <= s_tdata[IN_W-1:WGT_W];
        end
        if (cmd.dispatch)
        begin
            i_reg        <= '0;
            acc_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= nr_reg;
            res_bin_reg  <= '0;
            res_frac_reg <= '0;
            res_pos_reg  <= '0;
            res_dens_reg <= '0;
            res_prob_reg <= '0;
            res_tot_reg  <= '0;
            res_st_reg   <= ST_OK;
        end
        if (cmd.load_do)
        begin
            if (lp_eff < n_eff)
                res_bin_reg <= lp_eff[BIN_W-1:0];
            else
                res_st_reg <= ST_ERR;
        end
        if (cmd.not_ready)
            res_st_reg <= ST_ERR;
        if (cmd.fin_acc)
        begin
            acc_reg <= acc_next;
            i_reg   <= i_reg + 1'b1;
        end
        if (cmd.fin_end)
        begin
            res_tot_reg <= acc_reg;
            res_st_reg  <= (acc_reg == '0) ? ST_ZERO : ST_OK;
        end
        if (cmd.mul)
        begin
            t_reg  <= DIV_W'(u_reg) * DIV_W'(tot_reg);
            un_reg <= UN_W'(u_reg) * UN_W'(nr_reg);
        end
        if (cmd.qoff)
        begin
            off_reg      <= off_q[BIN_W-1:0];
            res_bin_reg  <= off_q[BIN_W-1:0];
            res_frac_reg <= Q_W'(un_reg - UN_W'({off_q, FRAC_BITS'(0)}));
            res_pos_reg  <= Q_W'(u_reg);
            res_st_reg   <= (tot_reg == '0) ? ST_ZERO : ST_OK;
        end
        if (cmd.zedge)
        begin
            res_st_reg <= ST_ZERO;
            if (u_reg != '0)
            begin
                res_bin_reg  <= nr_m1[BIN_W-1:0];
                res_frac_reg <= Q_W'(1) << FRAC_BITS;
                res_pos_reg  <= Q_W'(1) << FRAC_BITS;
            end
        end
        if (cmd.u0)
            off_reg <= '0;
        if (cmd.srch_issue)
            mid_reg <= mid_sum[CNT_W:1];
        if (cmd.srch_cmp)
        begin
            if ({p_rdata, FRAC_BITS'(0)} <= t_reg)
                lo_reg <= mid_reg;
            else
                hi_reg <= mid_reg - 1'b1;
        end
        if (cmd.srch_end)
        begin
            off_reg     <= off_lo[BIN_W-1:0];
            res_bin_reg <= off_lo[BIN_W-1:0];
        end
        if (cmd.wtake)
        begin
            w_reg <= w_rdata;
            p_reg <= (off_reg == '0) ? '0 : p_rdata;
        end
        if (cmd.wmul)
            wn_reg <= TOT_W'(w_reg) * TOT_W'(nr_reg);
        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                DV_FRAC:
                begin
                    if (w_reg == '0)
                        res_frac_reg <= '0;
                    else if (div_q > DIV_W'((1 << FRAC_BITS) - 1))
                        res_frac_reg <= Q_W'((1 << FRAC_BITS) - 1);
                    else
                        res_frac_reg <= div_q[Q_W-1:0];
                end
                DV_POS:  res_pos_reg <= div_q[Q_W-1:0];
                DV_LIM:
                begin
                    if (res_pos_reg > lim)
                        res_pos_reg <= lim;
                end
                DV_DENS: res_dens_reg <= div_q[DENS_W-1:0];
                default: res_prob_reg <= div_q[Q_W-1:0];
            endcase
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {PAD_W'(0), res_tot_reg, res_prob_reg, res_dens_reg,
                            res_pos_reg, res_frac_reg, res_bin_reg};
            m_tuser_reg <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.cmd         = cmd_reg;
    assign stat.table_ready = tr_reg;
    assign stat.total_zero  = (tot_reg == '0);
    assign stat.u_zero      = (u_reg == '0);
    assign stat.fin_last    = (i_reg == n_eff - 1'b1);
    assign stat.srch_more   = (lo_reg < hi_reg);
    assign stat.div_done    = div_done;
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule

// ===== hw/rtl/piecewise_constant_distribution_sampler.sv =====
// One request at a time: the result becomes valid in the same cycle that the next request
// can be taken. Finalize walks the bins over the weight memory and builds the prefix memory;
// a sample does a binary search of k steps over it (k <= 11 at 1024 bins).
// Samples and queries use the shared divider, one quotient bit per cycle (five divisions for a
// sample with nonzero u, two for a query or a sample with u zero, none when the total is zero).
// Async active-low reset clears control state only, not the weight or prefix memories.
module piecewise_constant_distribution_sampler
    import pcds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,  // active_count
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // weight, sample
    input  logic [1:0]        s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // bin_index, fraction, position, density, probability, total_sum
    output logic [1:0]        m_tuser    // status
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pcds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcds_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== hw/rtl/pcds_checker.sv =====
module pcds_assertions
    import pcds_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_ERR |-> m_tdata == '0)
        else $error("error result carries data");

    a_tot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[113:88] != '0 |-> m_tuser == ST_OK)
        else $error("nonzero total with bad status");

endmodule

bind piecewise_constant_distribution_sampler pcds_assertions u_pcds_assertions (.*);

// ===== verif/pcds_checker.sv =====
`timescale 1ns / 1ps

module pcds_checker
    import pcds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic [1:0]        m_tuser,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [Q_W-1:0]    frac;
        logic [Q_W-1:0]    pos;
        logic [DENS_W-1:0] dens;
        logic [Q_W-1:0]    prob;
        logic [TOT_W-1:0]  total;
        status_t           status;
    } bin_result_t;

    localparam longint ONE = 64'd1 << FRAC_BITS;

    longint      weights [MAX_BINS];
    longint      prefix [MAX_BINS+1];
    longint      fill_ptr;
    longint      total_w;
    logic        finalised;
    longint      latched_n;
    logic [CNT_W-1:0] bin_count_reg;
    bin_result_t expected_q [$];
    int          mismatches;

    assign errors  = mismatches;

    function automatic bin_result_t mk(longint b, longint f, longint p, longint d,
                                       longint pr, longint t, status_t s);
        bin_result_t r;
        r.bin = b[BIN_W-1:0];
        r.frac = f[Q_W-1:0];
        r.pos = p[Q_W-1:0];
        r.dens = d[DENS_W-1:0];
        r.prob = pr[Q_W-1:0];
        r.total = t[TOT_W-1:0];
        r.status = s;
        return r;
    endfunction

    function automatic bin_result_t predict_bin(cmd_t cmd, longint w_in, longint u);
        longint n;
        longint off;
        longint w;
        longint frac;
        longint pos;
        longint lim;
        longint t;
        longint lo;
        longint hi;
        longint mid;
        n = bin_count_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_BINS)
            n = MAX_BINS;
        if (cmd == CMD_LOAD)
        begin
            if (finalised)
            begin
                finalised = 1'b0;
                fill_ptr = 0;
                total_w = 0;
            end
            if (fill_ptr < n)
            begin
                weights[fill_ptr] = w_in;
                fill_ptr++;
                return mk(fill_ptr - 1, 0, 0, 0, 0, 0, ST_OK);
            end
            return mk(0, 0, 0, 0, 0, 0, ST_ERR);
        end
        if (cmd == CMD_FIN)
        begin
            prefix[0] = 0;
            for (int i = 0; i < n; i++)
            begin
                if (i >= fill_ptr)
                    weights[i] = 0;
                prefix[i+1] = prefix[i] + weights[i];
            end
            total_w = prefix[n];
            latched_n = n;
            finalised = 1'b1;
            return mk(0, 0, 0, 0, 0, total_w, (total_w == 0) ? ST_ZERO : ST_OK);
        end
        if (!finalised)
            return mk(0, 0, 0, 0, 0, 0, ST_ERR);
        n = latched_n;
        if (cmd == CMD_QUERY)
        begin
            off = (u * n) >> FRAC_BITS;
            if (off > n - 1)
                off = n - 1;
            frac = u * n - off * ONE;
            if (total_w == 0)
                return mk(off, frac, u, 0, 0, 0, ST_ZERO);
            w = weights[off];
            return mk(off, frac, u, (w * n * ONE) / total_w, (w * ONE) / total_w, 0, ST_OK);
        end
        if (total_w == 0)
        begin
            if (u == 0)
                return mk(0, 0, 0, 0, 0, 0, ST_ZERO);
            return mk(n - 1, ONE, ONE, 0, 0, 0, ST_ZERO);
        end
        if (u == 0)
        begin
            w = weights[0];
            return mk(0, 0, 0, (w * n * ONE) / total_w, (w * ONE) / total_w, 0, ST_OK);
        end
        t = u * total_w;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (prefix[mid] * ONE <= t)
                lo = mid;
            else
                hi = mid - 1;
        end
        off = (lo > n - 1) ? n - 1 : lo;
        w = weights[off];
        frac = (w == 0) ? 0 : (t - prefix[off] * ONE) / w;
        if (frac > ONE - 1)
            frac = ONE - 1;
        pos = (off * ONE + frac) / n;
        lim = ((off + 1) * ONE + n - 1) / n - 1;
        if (pos > lim)
            pos = lim;
        return mk(off, frac, pos, (w * n * ONE) / total_w, (w * ONE) / total_w, 0, ST_OK);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t e;
        bin_result_t g;
        if (!rst_n)
        begin
            fill_ptr = 0;
            total_w = 0;
            finalised = 1'b0;
            latched_n = 0;
            bin_count_reg = 11'd1024;
            expected_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                g.bin = m_tdata[9:0];
                g.frac = m_tdata[26:10];
                g.pos = m_tdata[43:27];
                g.dens = m_tdata[70:44];
                g.prob = m_tdata[87:71];
                g.total = m_tdata[113:88];
                g.status = status_t'(m_tuser);
                if (expected_q.size() == 0)
                    report("unexpected result, status", g.status, -1);
                else
                begin
                    e = expected_q.pop_front();
                    if (g.bin !== e.bin)
                        report("bin_index", g.bin, e.bin);
                    if (g.frac !== e.frac)
                        report("fraction", g.frac, e.frac);
                    if (g.pos !== e.pos)
                        report("position", g.pos, e.pos);
                    if (g.dens !== e.dens)
                        report("density", g.dens, e.dens);
                    if (g.prob !== e.prob)
                        report("probability", g.prob, e.prob);
                    if (g.total !== e.total)
                        report("total_sum", g.total, e.total);
                    if (g.status !== e.status)
                        report("status", g.status, e.status);
                end
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(),
                                  predict_bin(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]));
            if (cfg_we)
                bin_count_reg = cfg_data;
            pending = expected_q.size();
        end
    end

endmodule

// ===== verif/piecewise_constant_distribution_sampler_tb.sv =====
`timescale 1ns / 1ps

module piecewise_constant_distribution_sampler_tb;
    import pcds_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // weight, sample
    logic [1:0]        s_tuser;   // command
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // bin_index, fraction, position, density, probability, total_sum
    logic [1:0]        m_tuser;   // status
    int                errors;
    int                pending;
    int                quiet_cycles;
    int                sent;
    logic              busy_src;
    logic              busy_sink;

    piecewise_constant_distribution_sampler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pcds_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_request(cmd_t cmd, logic [15:0] w, logic [15:0] u);
        int gap;
        logic took;
        gap = busy_src ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {u, w};
        took = 1'b0;
        while (!took)
        begin
            #1 took = s_tready;
            @(negedge clk);
        end
        sent++;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_bins(int n);
        wait_idle();
        cfg_we = 1'b1;
        cfg_data = n[CNT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_weight(int style);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return (style == 0) ? 16'd0 : 16'($urandom_range(0, 3));
            default: return (style == 0) ? 16'd0 : 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_u();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // request source
    initial
    begin
        int n;
        int k;
        int m;
        int style;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        busy_src = 1'b1;
        sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(CMD_SAMPLE, 16'd0, 16'd1234);
        send_request(CMD_QUERY, 16'd0, 16'hFFFF);
        set_bins(4);
        send_request(CMD_LOAD, 16'hFFFF, 16'hFFFF);
        send_request(CMD_LOAD, 16'd0, 16'd0);
        send_request(CMD_LOAD, 16'd1, 16'd0);
        send_request(CMD_LOAD, 16'hFFFF, 16'd0);
        send_request(CMD_LOAD, 16'h5555, 16'd0);
        send_request(CMD_FIN, 16'd0, 16'd0);
        send_request(CMD_SAMPLE, 16'd0, 16'd0);
        send_request(CMD_SAMPLE, 16'd0, 16'hFFFF);
        send_request(CMD_SAMPLE, 16'd0, 16'd1);
        send_request(CMD_SAMPLE, 16'd0, 16'h8000);
        send_request(CMD_QUERY, 16'd0, 16'd0);
        send_request(CMD_QUERY, 16'd0, 16'h4000);
        set_bins(3);
        send_request(CMD_LOAD, 16'd0, 16'd0);
        send_request(CMD_LOAD, 16'd0, 16'd0);
        send_request(CMD_FIN, 16'd0, 16'd0);
        send_request(CMD_SAMPLE, 16'd0, 16'd0);
        send_request(CMD_SAMPLE, 16'd0, 16'd5);
        send_request(CMD_QUERY, 16'd0, 16'd40000);
        set_bins(1024);
        send_request(CMD_LOAD, 16'hFFFF, 16'd0);
        send_request(CMD_FIN, 16'd0, 16'd0);
        send_request(CMD_QUERY, 16'd0, 16'hFFFF);
        send_request(CMD_SAMPLE, 16'd0, 16'hFFFF);
        // changed count after finalize keeps the latched one
        set_bins(1);
        send_request(CMD_SAMPLE, 16'd0, 16'h7FFF);

        while (sent < 975)
        begin
            busy_src = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: n = 1;
                1: n = 1024;
                2: n = $urandom_range(2, 4);
                default: n = $urandom_range(1, 40);
            endcase
            set_bins(n);
            style = ($urandom_range(0, 9) == 0) ? 0 : 1;
            k = (n > 40) ? $urandom_range(0, 40) : $urandom_range(0, n + 2);
            for (int i = 0; i < k; i++)
                send_request(CMD_LOAD, pick_weight(style), 16'($urandom));
            if ($urandom_range(0, 12) == 0)
                send_request(CMD_SAMPLE, 16'($urandom), pick_u());
            send_request(CMD_FIN, 16'($urandom), 16'($urandom));
            m = $urandom_range(5, 30);
            for (int i = 0; i < m; i++)
                case ($urandom_range(0, 19))
                    0: send_request(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                    1, 2, 3, 4, 5: send_request(CMD_QUERY, 16'($urandom), pick_u());
                    default: send_request(CMD_SAMPLE, 16'($urandom), pick_u());
                endcase
            if ($urandom_range(0, 5) == 0)
            begin
                set_bins($urandom_range(1, 1024));
                send_request(CMD_SAMPLE, 16'd0, pick_u());
                send_request(CMD_QUERY, 16'd0, pick_u());
            end
        end

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("piecewise_constant_distribution_sampler_tb: done, clean");
        else
            $display("piecewise_constant_distribution_sampler_tb: done, errors");
        $finish;
    end

    // result sink
    initial
    begin
        int stall;
        m_tready = 1'b0;
        busy_sink = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) == 0)
                busy_sink = ~busy_sink;
            stall = busy_sink ? $urandom_range(0, 18) : 0;
            @(negedge clk);
            m_tready = 1'b0;
            repeat (stall) @(negedge clk);
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && quiet_cycles >= STALL_LIMIT)
        begin
            $display("piecewise_constant_distribution_sampler_tb: done, errors");
            $finish;
        end
    end

endmodule
